// ===== sv/apct_pkg.sv =====
`timescale 1ns / 1ps
// apct_pkg: shared types, widths and the per-axis overlap function
// for the pair contact tracker; depends on nothing
package apct_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned IdW    = 6;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } contact_event_e;

  typedef enum logic {
    OP_CHECK = 1'b0,
    OP_CLEAR = 1'b1
  } operation_e;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_CLEAR = 2'b10
  } state_e;

  // strict overlap on one axis: 2*|c1 - c2| < s1 + s2, no wrap anywhere
  function automatic logic axis_overlap(
    input logic signed [CoordW-1:0] c1,
    input logic        [CoordW-1:0] s1,
    input logic signed [CoordW-1:0] c2,
    input logic        [CoordW-1:0] s2
  );
    logic signed [CoordW:0] diff;
    logic        [CoordW-1:0] mag;
    logic        [CoordW:0] twice;
    logic        [CoordW:0] sum;
    diff  = {c1[CoordW-1], c1} - {c2[CoordW-1], c2};
    mag   = diff[CoordW] ? CoordW'(-diff) : diff[CoordW-1:0];
    twice = {mag, 1'b0};
    sum   = {1'b0, s1} + {1'b0, s2};
    return twice < sum;
  endfunction

endpackage

// ===== sv/aabb_pair_contact_tracker.sv =====
`timescale 1ns / 1ps
// aabb_pair_contact_tracker: box overlap test with per-pair contact memory
// depends on apct_pkg
//
// latency: done_o and the result are registered in the result register, which
//   follows the stage 1 register of the transfer
// throughput: one check per cycle while busy_o is low, set by the
//   contact memory read-modify-write with forwarding between back-to-back items
// reset and the clear operation each start a clearing pass over the contact
//   memory, one entry per cycle: busy_o stays high until the full 64 x 64
//   pair table is swept, results are never stalled by the receiver
module aabb_pair_contact_tracker
  import apct_pkg::*;
#(
  parameter int unsigned MAX_COLLIDERS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     operation_i,
  input  logic [IdW-1:0]           first_id_i,
  input  logic [IdW-1:0]           second_id_i,
  input  logic signed [CoordW-1:0] first_center_x_i,
  input  logic signed [CoordW-1:0] first_center_y_i,
  input  logic [CoordW-1:0]        first_width_i,
  input  logic [CoordW-1:0]        first_height_i,
  input  logic signed [CoordW-1:0] second_center_x_i,
  input  logic signed [CoordW-1:0] second_center_y_i,
  input  logic [CoordW-1:0]        second_width_i,
  input  logic [CoordW-1:0]        second_height_i,
  output logic                     done_o,
  output logic [1:0]               contact_event_o,
  output logic                     overlapping_o
);

  localparam int unsigned AddrW = 2 * IdW;
  localparam int unsigned Depth = 1 << AddrW;

  // one contact bit per ordered pair, address is {first id, second id}
  logic pair_contact_mem [Depth];

  state_e state_q, state_d;
  logic [AddrW-1:0] clr_cnt_q;

  logic accept;
  logic [AddrW-1:0] addr_in;
  logic pair_ok_in;

  // stage 1: registered item plus the memory read data
  logic s1_valid_q;
  logic s1_op_q;
  logic s1_pair_ok_q;
  logic [AddrW-1:0] s1_addr_q;
  logic signed [CoordW-1:0] s1_c1x_q, s1_c1y_q, s1_c2x_q, s1_c2y_q;
  logic [CoordW-1:0] s1_w1_q, s1_h1_q, s1_w2_q, s1_h2_q;
  logic rd_bit_q;
  logic fwd_hit_q, fwd_bit_q;

  logic s1_ov;
  logic s1_wr;
  logic s1_was;
  contact_event_e s1_event;

  // result register
  logic done_q;
  contact_event_e event_q;
  logic overlap_q;

  assign busy_o = (state_q == ST_CLEAR);
  assign accept = start_i && !busy_o;
  assign addr_in = {first_id_i, second_id_i};

  // equal ids and ids past the collider count leave the table alone
  assign pair_ok_in = (first_id_i != second_id_i) &&
                      (32'(first_id_i) < MAX_COLLIDERS) &&
                      (32'(second_id_i) < MAX_COLLIDERS);

  // clearing pass control
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN: begin
        if (accept && (operation_i == OP_CLEAR)) state_d = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (clr_cnt_q == {AddrW{1'b1}}) state_d = ST_RUN;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      // counter wraps back to zero at the end of each pass
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // stage 1 capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q      <= operation_i;
      s1_pair_ok_q <= pair_ok_in;
      s1_addr_q    <= addr_in;
      s1_c1x_q     <= first_center_x_i;
      s1_c1y_q     <= first_center_y_i;
      s1_w1_q      <= first_width_i;
      s1_h1_q      <= first_height_i;
      s1_c2x_q     <= second_center_x_i;
      s1_c2y_q     <= second_center_y_i;
      s1_w2_q      <= second_width_i;
      s1_h2_q      <= second_height_i;
      // the item ahead writes this same pair at this edge: take its new bit
      fwd_hit_q    <= s1_wr && (s1_addr_q == addr_in);
      fwd_bit_q    <= s1_ov;
    end
  end

  // memory: one write port (sweep or update), one registered read port
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      pair_contact_mem[clr_cnt_q] <= 1'b0;
    end else if (s1_wr) begin
      pair_contact_mem[s1_addr_q] <= s1_ov;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) rd_bit_q <= pair_contact_mem[addr_in];
  end

  // stage 1 evaluation
  assign s1_ov = axis_overlap(s1_c1x_q, s1_w1_q, s1_c2x_q, s1_w2_q) &&
                 axis_overlap(s1_c1y_q, s1_h1_q, s1_c2y_q, s1_h2_q);
  assign s1_wr  = s1_valid_q && (s1_op_q == OP_CHECK) && s1_pair_ok_q;
  assign s1_was = fwd_hit_q ? fwd_bit_q : rd_bit_q;

  always_comb begin
    s1_event = EV_NONE;
    if ((s1_op_q == OP_CHECK) && s1_pair_ok_q) begin
      if (s1_ov) s1_event = s1_was ? EV_STAY : EV_ENTER;
      else if (s1_was) s1_event = EV_EXIT;
    end
  end

  // result register, one-cycle strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      event_q   <= s1_event;
      overlap_q <= (s1_op_q == OP_CHECK) && s1_ov;
    end
  end

  assign done_o          = done_q;
  assign contact_event_o = event_q;
  assign overlapping_o   = overlap_q;

  // every result stems from a transfer held in stage 1 and then the result register
  a_done_from_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result without a matching transfer");

  // a clear transfer starts a clearing pass
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (operation_i == OP_CLEAR)) |=> busy_o)
    else $error("clear did not start the clearing pass");

  // enter and stay only with overlap, exit only without it
  a_event_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ((contact_event_o == EV_ENTER) || (contact_event_o == EV_STAY)))
      |-> overlapping_o)
    else $error("enter or stay reported without overlap");

  a_exit_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (contact_event_o == EV_EXIT)) |-> !overlapping_o)
    else $error("exit reported while overlapping");

endmodule

// ===== sim/tb_aabb_pair_contact_tracker.sv =====
`timescale 1ns / 1ps
// tb_aabb_pair_contact_tracker: self-checking bench for the pair contact tracker,
// with a queue-fed driver, a strobe monitor and a local contact table predictor
// depends on apct_pkg and aabb_pair_contact_tracker
module tb_aabb_pair_contact_tracker;
  import apct_pkg::*;

  localparam int unsigned NumColliders  = 64;
  localparam int unsigned RandomChecks  = 1725;
  localparam int unsigned PoolPairs     = 12;
  // a clear pass alone holds busy while it sweeps the whole pair table, so the limit sits well above it
  localparam int unsigned StallLimit    = 20000;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned MaxReports    = 10;

  // one check or clear transfer, plus how often the sender idles before it
  typedef struct {
    operation_e         op;
    logic [5:0]         a_id;
    logic [5:0]         b_id;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic [15:0]        aw;
    logic [15:0]        ah;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic [15:0]        bw;
    logic [15:0]        bh;
    int                 idle_pct;
  } pair_check_t;

  typedef struct {
    contact_event_e ev;
    logic           ov;
  } contact_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               operation_i = OP_CHECK;
  logic [5:0]         first_id_i = '0;
  logic [5:0]         second_id_i = '0;
  logic signed [15:0] first_center_x_i = '0;
  logic signed [15:0] first_center_y_i = '0;
  logic [15:0]        first_width_i = '0;
  logic [15:0]        first_height_i = '0;
  logic signed [15:0] second_center_x_i = '0;
  logic signed [15:0] second_center_y_i = '0;
  logic [15:0]        second_width_i = '0;
  logic [15:0]        second_height_i = '0;
  logic               busy_o;
  logic               done_o;
  logic [1:0]         contact_event_o;
  logic               overlapping_o;

  // stimulus waiting for the driver, and results the monitor still owes
  pair_check_t     pending_checks[$];
  contact_result_t expected_contacts[$];
  pair_check_t     on_bus;
  bit              holding = 1'b0;

  // bench copy of the per-pair contact bits
  bit contact_map [NumColliders*NumColliders];

  int mismatches = 0;
  int stall_cycles = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_clears = 0;
  int n_touching = 0;
  int ev_seen [4];

  logic [5:0] pool_a [PoolPairs];
  logic [5:0] pool_b [PoolPairs];

  aabb_pair_contact_tracker #(
    .MAX_COLLIDERS(NumColliders)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .operation_i      (operation_i),
    .first_id_i       (first_id_i),
    .second_id_i      (second_id_i),
    .first_center_x_i (first_center_x_i),
    .first_center_y_i (first_center_y_i),
    .first_width_i    (first_width_i),
    .first_height_i   (first_height_i),
    .second_center_x_i(second_center_x_i),
    .second_center_y_i(second_center_y_i),
    .second_width_i   (second_width_i),
    .second_height_i  (second_height_i),
    .done_o           (done_o),
    .contact_event_o  (contact_event_o),
    .overlapping_o    (overlapping_o)
  );

  always #5 clk_i = ~clk_i;

  // strict overlap on one axis, done in plain int so nothing can wrap
  function automatic bit span_hit(int c1, int s1, int c2, int s2, ref int touched);
    int gap;
    gap = c1 - c2;
    if (gap < 0) begin
      gap = -gap;
    end
    if (2 * gap == s1 + s2) begin
      touched = 1;
    end
    return 2 * gap < s1 + s2;
  endfunction

  // updates the contact table and returns what the tracker should report
  function automatic contact_result_t track_contact(pair_check_t c);
    contact_result_t r;
    int              touched;
    int              slot;
    bit              hit_x;
    bit              hit_y;
    r.ev    = EV_NONE;
    r.ov    = 1'b0;
    touched = 0;
    if (c.op == OP_CLEAR) begin
      foreach (contact_map[i]) begin
        contact_map[i] = 1'b0;
      end
      n_clears++;
    end else begin
      hit_x = span_hit(int'(c.ax), int'(c.aw), int'(c.bx), int'(c.bw), touched);
      hit_y = span_hit(int'(c.ay), int'(c.ah), int'(c.by), int'(c.bh), touched);
      r.ov  = hit_x && hit_y;
      n_touching += touched;
      // equal ids and out-of-range ids only report the geometry
      if (c.a_id != c.b_id && c.a_id < NumColliders && c.b_id < NumColliders) begin
        slot = int'(c.a_id) * NumColliders + int'(c.b_id);
        if (r.ov) begin
          r.ev = contact_map[slot] ? EV_STAY : EV_ENTER;
          contact_map[slot] = 1'b1;
        end else if (contact_map[slot]) begin
          r.ev = EV_EXIT;
          contact_map[slot] = 1'b0;
        end
      end
    end
    ev_seen[r.ev]++;
    return r;
  endfunction

  task automatic add_check(input logic [5:0] a, input logic [5:0] b,
                           input int ax, input int ay, input int aw, input int ah,
                           input int bx, input int by, input int bw, input int bh);
    pair_check_t c;
    c.op = OP_CHECK;
    c.a_id = a;
    c.b_id = b;
    c.ax = 16'(ax);
    c.ay = 16'(ay);
    c.aw = 16'(aw);
    c.ah = 16'(ah);
    c.bx = 16'(bx);
    c.by = 16'(by);
    c.bw = 16'(bw);
    c.bh = 16'(bh);
    c.idle_pct = 0;
    pending_checks.push_back(c);
  endtask

  task automatic add_clear(input logic [15:0] filler);
    pair_check_t c;
    c.op = OP_CLEAR;
    c.a_id = filler[5:0];
    c.b_id = filler[5:0];
    c.ax = filler;
    c.ay = filler;
    c.aw = filler;
    c.ah = filler;
    c.bx = filler;
    c.by = filler;
    c.bw = filler;
    c.bh = filler;
    c.idle_pct = 0;
    pending_checks.push_back(c);
  endtask

  // random transfer: mostly repeat visits to a small set of pairs with nearby
  // boxes so enter/stay/exit chains form, some exact touching, rare clears,
  // and the rest fully random noise across every bit
  function automatic pair_check_t random_check(int idle_pct);
    pair_check_t c;
    int          pick;
    int          base_x;
    int          base_y;
    int          span2;
    pick = $urandom_range(99);
    c.op = OP_CHECK;
    c.a_id = 6'($urandom);
    c.b_id = 6'($urandom);
    c.ax = 16'($urandom);
    c.ay = 16'($urandom);
    c.aw = 16'($urandom);
    c.ah = 16'($urandom);
    c.bx = 16'($urandom);
    c.by = 16'($urandom);
    c.bw = 16'($urandom);
    c.bh = 16'($urandom);
    c.idle_pct = idle_pct;
    if (pick < 2) begin
      c.op = OP_CLEAR;
    end else if (pick < 78) begin
      pick   = $urandom_range(PoolPairs - 1);
      c.a_id = pool_a[pick];
      c.b_id = pool_b[pick];
      base_x = int'($urandom_range(64000)) - 32000;
      base_y = int'($urandom_range(64000)) - 32000;
      c.ax = 16'(base_x + int'($urandom_range(512)) - 256);
      c.ay = 16'(base_y + int'($urandom_range(512)) - 256);
      c.bx = 16'(base_x + int'($urandom_range(512)) - 256);
      c.by = 16'(base_y + int'($urandom_range(512)) - 256);
      c.aw = 16'($urandom_range(512));
      c.ah = 16'($urandom_range(512));
      c.bw = 16'($urandom_range(512));
      c.bh = 16'($urandom_range(512));
      // force an exact touch on one axis now and then
      if ($urandom_range(99) < 15) begin
        if ($urandom_range(1) == 0) begin
          span2 = int'(c.ax) - int'(c.bx);
          span2 = 2 * (span2 < 0 ? -span2 : span2);
          c.aw = 16'($urandom_range(span2));
          c.bw = 16'(span2 - int'(c.aw));
        end else begin
          span2 = int'(c.ay) - int'(c.by);
          span2 = 2 * (span2 < 0 ? -span2 : span2);
          c.ah = 16'($urandom_range(span2));
          c.bh = 16'(span2 - int'(c.ah));
        end
      end
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
  endtask

  // driver: on each accepted transfer predict its result, then either hold the
  // current item, launch the next one, or idle; start_i gets one assignment
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_contacts.push_back(track_contact(on_bus));
        n_accepted++;
        holding = 1'b0;
      end
      if (!holding) begin
        if (pending_checks.size() > 0 &&
            $urandom_range(99) >= pending_checks[0].idle_pct) begin
          on_bus = pending_checks.pop_front();
          holding = 1'b1;
          start_i           <= 1'b1;
          operation_i       <= on_bus.op;
          first_id_i        <= on_bus.a_id;
          second_id_i       <= on_bus.b_id;
          first_center_x_i  <= on_bus.ax;
          first_center_y_i  <= on_bus.ay;
          first_width_i     <= on_bus.aw;
          first_height_i    <= on_bus.ah;
          second_center_x_i <= on_bus.bx;
          second_center_y_i <= on_bus.by;
          second_width_i    <= on_bus.bw;
          second_height_i   <= on_bus.bh;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobe is matched against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      n_results++;
      if (expected_contacts.size() == 0) begin
        report_mismatch($sformatf("result ev=%0d ov=%0b with nothing pending",
                                  contact_event_o, overlapping_o));
      end else begin
        if (contact_event_o !== expected_contacts[0].ev) begin
          report_mismatch($sformatf("contact_event exp %s got %0d",
                                    expected_contacts[0].ev.name(), contact_event_o));
        end
        if (overlapping_o !== expected_contacts[0].ov) begin
          report_mismatch($sformatf("overlapping exp %0b got %0b",
                                    expected_contacts[0].ov, overlapping_o));
        end
        void'(expected_contacts.pop_front());
      end
    end
  end

  // watchdog: any transfer in either direction restarts the count
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles", stall_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int phase_pct [4];
    phase_pct = '{0, 50, 0, 17};
    foreach (ev_seen[i]) begin
      ev_seen[i] = 0;
    end
    // pair pool: one pair with equal ids, one mirrored pair, rest random
    foreach (pool_a[i]) begin
      pool_a[i] = 6'($urandom);
      pool_b[i] = 6'($urandom);
    end
    pool_b[0] = pool_a[0];
    pool_a[2] = pool_b[1];
    pool_b[2] = pool_a[1];

    // directed: enter, stay, mirrored pair, exit, none
    add_check(6'd1, 6'd2, 0, 0, 16, 16, 0, 0, 16, 16);
    add_check(6'd1, 6'd2, 4, 4, 16, 16, 0, 0, 16, 16);
    add_check(6'd2, 6'd1, 0, 0, 16, 16, 0, 0, 16, 16);
    add_check(6'd1, 6'd2, 0, 0, 16, 16, 100, 0, 16, 16);
    add_check(6'd1, 6'd2, 0, 0, 16, 16, 100, 0, 16, 16);
    // equal ids report geometry only
    add_check(6'd5, 6'd5, 0, 0, 16, 16, 0, 0, 16, 16);
    // touching on x is no overlap, one lsb more is
    add_check(6'd3, 6'd4, 0, 0, 32, 32, 32, 0, 32, 32);
    add_check(6'd3, 6'd4, 0, 0, 33, 32, 32, 0, 32, 32);
    // touching on y while x overlaps ends the contact
    add_check(6'd3, 6'd4, 0, 0, 32, 32, 0, 32, 32, 32);
    // extreme corners with the largest sizes only touch, the same corner overlaps
    add_check(6'd63, 6'd0, -32768, -32768, 65535, 65535, 32767, 32767, 65535, 65535);
    add_check(6'd63, 6'd0, 32767, 32767, 65535, 65535, 32767, 32767, 65535, 65535);
    // zero sizes on both boxes never overlap, even on the same centre; a size of one on one box does
    add_check(6'd63, 6'd0, 100, 100, 0, 0, 100, 100, 0, 0);
    add_check(6'd0, 6'd63, -32768, -32768, 1, 1, -32768, -32768, 0, 0);
    // a clear wipes every pair, including one still in contact
    add_clear(16'h0000);
    add_check(6'd0, 6'd63, -32768, -32768, 1, 1, -32768, -32768, 0, 0);
    add_check(6'd2, 6'd1, 0, 0, 16, 16, 500, 0, 16, 16);
    add_clear(16'hffff);
    add_check(6'd62, 6'd61, -100, -100, 30, 30, -90, -90, 0, 0);
    add_check(6'd63, 6'd63, -1, -1, 65535, 65535, -1, -1, 65535, 65535);
    add_check(6'd42, 6'd21, 32767, -32768, 65535, 65535, -32768, 32767, 65535, 65535);

    // random part in four idle phases
    for (int k = 0; k < RandomChecks; k++) begin
      pending_checks.push_back(random_check(phase_pct[(k * 4) / RandomChecks]));
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_checks.size() > 0 || holding || expected_contacts.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);

    $display("%0d transfers (%0d clears), %0d results, %0d with a touching axis",
             n_accepted, n_clears, n_results, n_touching);
    $display("events: none %0d, enter %0d, stay %0d, exit %0d; mismatches %0d",
             ev_seen[EV_NONE], ev_seen[EV_ENTER], ev_seen[EV_STAY], ev_seen[EV_EXIT],
             mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
